@@ src/indexed_array_insert_erase_top_defines.svh @@
// Assertion macros shared by the indexed array RTL.
// Included by the modules that carry concurrent checks; depends on clk and arst_n in scope.
`ifndef INDEXED_ARRAY_INSERT_ERASE_TOP_DEFINES_SVH
`define INDEXED_ARRAY_INSERT_ERASE_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define IAIE_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("%m: check failed");
`define IAIE_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("%m: check failed");
`else
`define IAIE_ASSERT(label, prop)
`define IAIE_ASSERT_ALWAYS(label, prop)
`endif
`endif

@@ src/iaie_pkg.sv @@
// Shared types and codes for the indexed array with insert and erase.
// No dependencies; used by iaie_ctrl and indexed_array_insert_erase_top.
package iaie_pkg;

	localparam int CAPACITY_DEF = 256;
	localparam int WORD_W = 32;

	localparam logic [2:0] OP_GET    = 3'd0;
	localparam logic [2:0] OP_SET    = 3'd1;
	localparam logic [2:0] OP_APPEND = 3'd2;
	localparam logic [2:0] OP_INSERT = 3'd3;
	localparam logic [2:0] OP_ERASE  = 3'd4;
	localparam logic [2:0] OP_RESIZE = 3'd5;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_OOB  = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	// Request as it arrives on the slave stream, last field (opcode) in the low bits.
	typedef struct packed {
		logic [8:0]               length;
		logic signed [WORD_W-1:0] value;
		logic [8:0]               index;
		logic [2:0]               opcode;
	} item_t;

	typedef struct packed {
		logic [8:0]               count;
		logic [1:0]               status;
		logic signed [WORD_W-1:0] read_value;
	} res_t;

endpackage

@@ src/iaie_mem.sv @@
// Element store: single write port, single read port, registered read data.
// No package dependencies; instantiated by indexed_array_insert_erase_top.
module iaie_mem #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0] mem [DEPTH];
	logic [31:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/iaie_ctrl.sv @@
// Request sequencer: decodes one request, walks the store for shifts and zero fill,
// and holds the fill count. Depends on iaie_pkg and the assertion macro header.
`include "indexed_array_insert_erase_top_defines.svh"

module iaie_ctrl #(
	parameter int CAPACITY = iaie_pkg::CAPACITY_DEF,
	parameter int AW       = $clog2(CAPACITY)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  iaie_pkg::item_t      in_item,
	output logic                 res_valid,
	input  logic                 res_ready,
	output iaie_pkg::res_t       res,
	output logic                 mem_we,
	output logic [AW-1:0]        mem_waddr,
	output logic [31:0]          mem_wdata,
	output logic                 mem_re,
	output logic [AW-1:0]        mem_raddr,
	input  logic [31:0]          mem_rdata
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > 10) ? CW : 10;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SHIFT = 6'b000010,
		S_LAST  = 6'b000100,
		S_FILL  = 6'b001000,
		S_GET   = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t        state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [AW-1:0] wp_q, wp_d;
	logic [AW-1:0] idx_q, idx_d;
	logic [CW-1:0] len_q, len_d;
	logic [31:0]   val_q, val_d;
	logic          up_q, up_d;
	logic [1:0]    st_q, st_d;
	logic [31:0]   rd_q, rd_d;

	logic [XW-1:0] idx_x, cnt_x, len_x, cap_x, wp_x, idx_qx, len_qx;

	assign idx_x  = XW'(in_item.index);
	assign cnt_x  = XW'(cnt_q);
	assign len_x  = XW'(in_item.length);
	assign cap_x  = XW'(CAPACITY);
	assign wp_x   = XW'(wp_q);
	assign idx_qx = XW'(idx_q);
	assign len_qx = XW'(len_q);

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		wp_d      = wp_q;
		idx_d     = idx_q;
		len_d     = len_q;
		val_d     = val_q;
		up_d      = up_q;
		st_d      = st_q;
		rd_d      = rd_q;
		mem_we    = 1'b0;
		mem_waddr = wp_q;
		mem_wdata = mem_rdata;
		mem_re    = 1'b0;
		mem_raddr = wp_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					st_d    = iaie_pkg::ST_OK;
					rd_d    = '0;
					val_d   = in_item.value;
					idx_d   = AW'(in_item.index);
					len_d   = CW'(in_item.length);
					state_d = S_DONE;
					unique case (in_item.opcode)
						iaie_pkg::OP_GET: begin
							if (idx_x >= cnt_x) begin
								st_d = iaie_pkg::ST_OOB;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = AW'(in_item.index);
								state_d   = S_GET;
							end
						end
						iaie_pkg::OP_SET: begin
							if (idx_x >= cnt_x) begin
								st_d = iaie_pkg::ST_OOB;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = AW'(in_item.index);
								mem_wdata = in_item.value;
							end
						end
						iaie_pkg::OP_APPEND: begin
							if (cnt_x >= cap_x) begin
								st_d = iaie_pkg::ST_FULL;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = AW'(cnt_q);
								mem_wdata = in_item.value;
								cnt_d     = cnt_q + CW'(1);
							end
						end
						iaie_pkg::OP_INSERT: begin
							if (idx_x > cnt_x) begin
								st_d = iaie_pkg::ST_OOB;
							end else if (cnt_x >= cap_x) begin
								st_d = iaie_pkg::ST_FULL;
							end else if (idx_x == cnt_x) begin
								mem_we    = 1'b1;
								mem_waddr = AW'(in_item.index);
								mem_wdata = in_item.value;
								cnt_d     = cnt_q + CW'(1);
							end else begin
								// Move entries up from the top, one read ahead of each write.
								mem_re    = 1'b1;
								mem_raddr = AW'(cnt_q - CW'(1));
								wp_d      = AW'(cnt_q);
								up_d      = 1'b1;
								state_d   = S_SHIFT;
							end
						end
						iaie_pkg::OP_ERASE: begin
							if (idx_x >= cnt_x) begin
								st_d = iaie_pkg::ST_OOB;
							end else if (idx_x + XW'(1) == cnt_x) begin
								cnt_d = cnt_q - CW'(1);
							end else begin
								mem_re    = 1'b1;
								mem_raddr = AW'(in_item.index) + AW'(1);
								wp_d      = AW'(in_item.index);
								up_d      = 1'b0;
								state_d   = S_SHIFT;
							end
						end
						iaie_pkg::OP_RESIZE: begin
							if (len_x > cap_x) begin
								st_d = iaie_pkg::ST_FULL;
							end else if (len_x <= cnt_x) begin
								cnt_d = CW'(in_item.length);
							end else begin
								wp_d    = AW'(cnt_q);
								state_d = S_FILL;
							end
						end
						default: ;
					endcase
				end
			end
			S_SHIFT: begin
				// Data read last cycle lands one place up or down.
				mem_we    = 1'b1;
				mem_waddr = wp_q;
				mem_wdata = mem_rdata;
				if (up_q) begin
					if (wp_x == idx_qx + XW'(1)) begin
						state_d = S_LAST;
					end else begin
						mem_re    = 1'b1;
						mem_raddr = wp_q - AW'(2);
						wp_d      = wp_q - AW'(1);
					end
				end else begin
					if (wp_x + XW'(2) == cnt_x) begin
						cnt_d   = cnt_q - CW'(1);
						state_d = S_DONE;
					end else begin
						mem_re    = 1'b1;
						mem_raddr = wp_q + AW'(2);
						wp_d      = wp_q + AW'(1);
					end
				end
			end
			S_LAST: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q;
				mem_wdata = val_q;
				cnt_d     = cnt_q + CW'(1);
				state_d   = S_DONE;
			end
			S_FILL: begin
				mem_we    = 1'b1;
				mem_waddr = wp_q;
				mem_wdata = '0;
				if (wp_x + XW'(1) == len_qx) begin
					cnt_d   = len_q;
					state_d = S_DONE;
				end else begin
					wp_d = wp_q + AW'(1);
				end
			end
			S_GET: begin
				rd_d    = mem_rdata;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		wp_q  <= wp_d;
		idx_q <= idx_d;
		len_q <= len_d;
		val_q <= val_d;
		up_q  <= up_d;
		st_q  <= st_d;
		rd_q  <= rd_d;
	end

	assign in_ready       = (state_q == S_IDLE);
	assign res_valid      = (state_q == S_DONE);
	assign res.count      = 9'(cnt_q);
	assign res.status     = st_q;
	assign res.read_value = rd_q;

	`IAIE_ASSERT_ALWAYS(a_reset_idle, !arst_n |=> (state_q == S_IDLE && cnt_q == '0))
	`IAIE_ASSERT(a_cnt_bound, cnt_x <= cap_x)
	`IAIE_ASSERT(a_cnt_moves_into_done, !$stable(cnt_q) |-> state_q == S_DONE)
	`IAIE_ASSERT(a_up_shift_above_idx, (state_q == S_SHIFT && up_q) |-> wp_x > idx_qx)
	`IAIE_ASSERT(a_get_has_read, (state_q == S_GET) |-> $past(mem_re))

endmodule

@@ src/indexed_array_insert_erase_top.sv @@
// Bounded array of 32-bit words with a fill count: get, set, append, insert, erase, resize.
// Usage:
//   Requests arrive on the s_ stream; one result per request leaves on the m_ stream.
//   One request is worked on at a time; s_tready is high while the sequencer is idle.
//   Get reads the store before its result is ready; set, append, insert at the count,
//   shrinking resize, unused opcodes, out-of-range and refused requests go straight
//   to the result. Insert below the count moves entries up and then writes the value,
//   erase below the top moves entries down, and a growing resize zero-fills up to
//   new_length; all moves and zero fill go through the single write port of the
//   element store, one entry per cycle.
//   Results pass through an output register, so a new request can be taken while
//   the previous result still waits; a stalled m_tready holds that result, and the
//   sequencer then waits with its next result until the register drains.
//   Reset clears the fill count and the sequencer; the store itself is not cleared
//   and entries at or above the count are never read.
// Depends on iaie_pkg, iaie_ctrl and iaie_mem.
module indexed_array_insert_erase_top #(
	parameter int CAPACITY = iaie_pkg::CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // opcode[2:0], index[11:3], value[43:12], length[52:44], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // read_value[31:0], status[33:32], count[42:34], zero pad
);

	localparam int AW = $clog2(CAPACITY);

	iaie_pkg::item_t in_item;
	iaie_pkg::res_t  res;
	iaie_pkg::res_t  res_q;
	logic            res_valid;
	logic            res_ready;
	logic            m_tvalid_q;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [31:0]   mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [31:0]   mem_rdata;

	assign in_item = s_tdata[$bits(iaie_pkg::item_t)-1:0];

	iaie_ctrl #(
		.CAPACITY (CAPACITY),
		.AW       (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_item   (in_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	iaie_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Output register: refills in the same cycle that its result is taken.
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'b0, res_q};

endmodule
